[rtl/ffbp_pkg.sv]
// Package for the first-fit bin packer: transaction structs, the token control group
// that travels along the cell chain, and fixed field widths. No dependencies.
package ffbp_pkg;

    localparam int CAP_W     = 16;
    localparam int TYPE_W    = 10;
    localparam int WEIGHT_W  = 16;
    localparam int COPIES_W  = 7;
    localparam int BIN_IDX_W = 8;
    localparam int USED_W    = 9;

    localparam logic [COPIES_W-1:0] MAX_COPIES = 7'd64;
    localparam logic [CAP_W-1:0]    CAP_RESET  = 16'hFFFF;

    typedef struct packed {
        logic                start_req;
        logic [TYPE_W-1:0]   item_type;
        logic [WEIGHT_W-1:0] weight;
        logic [COPIES_W-1:0] copies;
    } t_in_item;

    typedef struct packed {
        logic [BIN_IDX_W-1:0] bin_index;
        logic [TYPE_W-1:0]    placed_type;
        logic                 opened_new;
        logic                 oversize;
        logic                 table_full;
        logic [USED_W-1:0]    bins_used;
        logic                 last;
    } t_out_item;

    typedef struct packed {
        logic valid;
        logic clr;
        logic has_res;
        logic last;
        logic placed;
        logic opened;
        logic over;
    } t_tok_ctrl;

endpackage

[rtl/ffbp_cell.sv]
// One bin of the first-fit chain: holds the bin's load and open flag and passes
// the copy token on to the next cell. Depends on ffbp_pkg.
module ffbp_cell import ffbp_pkg::*; #(
    parameter int INDEX       = 0,
    parameter int IDX_W       = 8,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  logic [CAP_W-1:0]       i_cap,
    input  t_tok_ctrl              i_ctl,
    input  logic [IDX_W-1:0]       i_idx,
    input  logic [WEIGHT_BITS-1:0] i_w,
    input  logic [TYPE_W-1:0]      i_type,
    output t_tok_ctrl              o_ctl,
    output logic [IDX_W-1:0]       o_idx,
    output logic [WEIGHT_BITS-1:0] o_w,
    output logic [TYPE_W-1:0]      o_type
);

    localparam int CW = ((WEIGHT_BITS > CAP_W) ? WEIGHT_BITS : CAP_W) + 1;

    logic                   r_open;
    logic [WEIGHT_BITS-1:0] r_load;
    t_tok_ctrl              r_ctl;
    logic [IDX_W-1:0]       r_idx;
    logic [WEIGHT_BITS-1:0] r_w;
    logic [TYPE_W-1:0]      r_type;

    logic                   n_open;
    logic [WEIGHT_BITS-1:0] n_load;
    t_tok_ctrl              n_ctl;
    logic [IDX_W-1:0]       n_idx;
    logic                   open_eff;
    logic                   want;
    logic [CW-1:0]          sum;
    logic                   fit;

    always_comb begin
        open_eff = r_open && !(i_ctl.valid && i_ctl.clr);
        want     = i_ctl.valid && i_ctl.has_res && !i_ctl.placed;
        sum      = CW'(r_load) + CW'(i_w);
        fit      = sum <= CW'(i_cap);
        n_open   = open_eff;
        n_load   = r_load;
        n_ctl    = i_ctl;
        n_idx    = i_idx;
        if (want) begin
            if (open_eff && fit) begin
                n_load       = sum[WEIGHT_BITS-1:0];
                n_ctl.placed = 1'b1;
                n_idx        = IDX_W'(INDEX);
            end else if (!open_eff) begin
                n_open       = 1'b1;
                n_load       = i_w;
                n_ctl.placed = 1'b1;
                n_ctl.opened = 1'b1;
                n_ctl.over   = CW'(i_w) > CW'(i_cap);
                n_idx        = IDX_W'(INDEX);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_ctl  <= '0;
        end else if (i_adv) begin
            r_open <= n_open;
            r_ctl  <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_load <= n_load;
            r_idx  <= n_idx;
            r_w    <= i_w;
            r_type <= i_type;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_idx  = r_idx;
    assign o_w    = r_w;
    assign o_type = r_type;

endmodule

[rtl/ffbp_feed.sv]
// Input stage of the packer: takes one item transaction and issues one token per
// copy into the cell chain. Depends on ffbp_pkg.
module ffbp_feed import ffbp_pkg::*; #(
    parameter int WEIGHT_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_item               i_in_item,
    output t_tok_ctrl              o_ctl,
    output logic [WEIGHT_BITS-1:0] o_w,
    output logic [TYPE_W-1:0]      o_type
);

    localparam int EW = (WEIGHT_BITS > WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;

    logic                   r_busy;
    logic                   r_clr;
    logic [COPIES_W-1:0]    r_rem;
    logic [WEIGHT_BITS-1:0] r_w;
    logic [TYPE_W-1:0]      r_type;

    logic                   emit_last;
    logic                   accept;
    logic [COPIES_W-1:0]    n_rem;
    logic [EW-1:0]          w_ext;

    always_comb begin
        emit_last  = r_busy && (r_rem <= COPIES_W'(1));
        o_in_ready = !r_busy || (i_adv && emit_last);
        accept     = i_in_valid && o_in_ready;
        n_rem      = (i_in_item.copies > MAX_COPIES) ? MAX_COPIES : i_in_item.copies;
        w_ext      = EW'(i_in_item.weight);
        o_ctl         = '0;
        o_ctl.valid   = r_busy;
        o_ctl.clr     = r_clr;
        o_ctl.has_res = r_rem != '0;
        o_ctl.last    = r_rem == COPIES_W'(1);
        o_w    = r_w;
        o_type = r_type;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_clr  <= 1'b0;
            r_rem  <= '0;
        end else begin
            if (i_adv && r_busy) begin
                r_clr <= 1'b0;
                if (emit_last) begin
                    r_busy <= 1'b0;
                    r_rem  <= '0;
                end else begin
                    r_rem <= r_rem - COPIES_W'(1);
                end
            end
            if (accept) begin
                r_busy <= 1'b1;
                r_clr  <= i_in_item.start_req;
                r_rem  <= n_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_w    <= w_ext[WEIGHT_BITS-1:0];
            r_type <= i_in_item.item_type;
        end
    end

endmodule

[rtl/first_fit_bin_packer_top.sv]
// First-fit bin packer top level: feed stage, a chain of MAX_BINS bin cells and the
// result register. Depends on ffbp_pkg, ffbp_feed and ffbp_cell.
//
// Usage: an input transaction carries an item type, a weight and a copy count
// (0 to 64, larger counts saturate to 64). Each copy yields one output
// transaction naming the lowest-numbered open bin with room for it, or a newly
// opened bin, or a table-full mark when every bin is open and none fits.
// A set start_req empties all bins before the copies of that item are placed,
// even when the copy count is zero (such an item gives no result).
// Each copy travels as a token through one cell per bin, one cell per cycle while
// the chain is not stalled; the result register follows the last cell.
// The feed stage issues one copy per cycle while the chain advances, and a single
// token for an item with no copies; items follow each other without gaps.
// The bin capacity register is written through i_cfg_we / i_cfg_data and is
// 65535 after reset; it should only be changed while no copy is in flight.
// Reset closes every bin; no clearing pass is needed.
// When the receiver stalls, the chain holds still; an idle feed stage may still take an item.
module first_fit_bin_packer_top import ffbp_pkg::*; #(
    parameter int MAX_BINS    = 256,
    parameter int WEIGHT_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data
);

    localparam int IDX_W = $clog2(MAX_BINS);
    localparam int CNT_W = $clog2(MAX_BINS + 1);

    logic [CAP_W-1:0] r_cap;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;
    t_out_item        r_out_item;

    logic             adv;
    logic [CNT_W-1:0] n_cnt;
    t_tok_ctrl        tok;
    logic [31:0]      idx_ext;
    logic [31:0]      cnt_ext;

    t_tok_ctrl              c_ctl  [MAX_BINS+1];
    logic [IDX_W-1:0]       c_idx  [MAX_BINS+1];
    logic [WEIGHT_BITS-1:0] c_w    [MAX_BINS+1];
    logic [TYPE_W-1:0]      c_type [MAX_BINS+1];

    assign adv      = !r_out_valid || i_out_ready;
    assign c_idx[0] = '0;

    ffbp_feed #(
        .WEIGHT_BITS(WEIGHT_BITS)
    ) u_feed (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_ctl      (c_ctl[0]),
        .o_w        (c_w[0]),
        .o_type     (c_type[0])
    );

    for (genvar k = 0; k < MAX_BINS; k++) begin : g_cell
        ffbp_cell #(
            .INDEX      (k),
            .IDX_W      (IDX_W),
            .WEIGHT_BITS(WEIGHT_BITS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_adv  (adv),
            .i_cap  (r_cap),
            .i_ctl  (c_ctl[k]),
            .i_idx  (c_idx[k]),
            .i_w    (c_w[k]),
            .i_type (c_type[k]),
            .o_ctl  (c_ctl[k+1]),
            .o_idx  (c_idx[k+1]),
            .o_w    (c_w[k+1]),
            .o_type (c_type[k+1])
        );
    end

    always_comb begin
        tok     = c_ctl[MAX_BINS];
        n_cnt   = (tok.clr ? '0 : r_cnt) + CNT_W'(tok.opened);
        idx_ext = 32'(c_idx[MAX_BINS]);
        cnt_ext = 32'(n_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (adv) begin
                r_out_valid <= tok.valid && tok.has_res;
                if (tok.valid) begin
                    r_cnt <= n_cnt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && tok.valid && tok.has_res) begin
            r_out_item.bin_index   <= idx_ext[BIN_IDX_W-1:0];
            r_out_item.placed_type <= c_type[MAX_BINS];
            r_out_item.opened_new  <= tok.opened;
            r_out_item.oversize    <= tok.over;
            r_out_item.table_full  <= !tok.placed;
            r_out_item.bins_used   <= cnt_ext[USED_W-1:0];
            r_out_item.last        <= tok.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= MAX_BINS)
        else $error("open bin count exceeds the number of bins");

    a_full_means_all_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.table_full |-> 32'(r_cnt) == MAX_BINS)
        else $error("copy dropped while a bin was still free");

    a_full_not_opened: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.table_full |-> !o_out_item.opened_new && !o_out_item.oversize)
        else $error("dropped copy marked as placed");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(r_cnt))
        else $error("bin count changed while the result was stalled");

endmodule

[sim/tb.sv]
// Self-checking testbench for first_fit_bin_packer_top: a directed opening, then random
// packing sequences under several bin capacities and handshake idling patterns.
// Depends on ffbp_pkg and the RTL of the packer.
`timescale 1ns / 1ps

module tb;
    import ffbp_pkg::*;

    localparam int NUM_BINS         = 256;
    localparam int SETTLE_CYCLES    = 2 * NUM_BINS;
    localparam int RANDOM_PER_PHASE = 36;
    localparam int NUM_PHASES       = 8;
    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int MAX_REPORTS      = 40;

    class placement_scoreboard;
        logic [CAP_W-1:0]    capacity;
        logic [WEIGHT_W-1:0] bin_load [NUM_BINS];
        int unsigned         open_bins;
        t_out_item           expected_placements [$];
        int unsigned         errors;
        int unsigned         inputs_seen;
        int unsigned         results_seen;
        int unsigned         opened_seen;
        int unsigned         oversize_seen;
        int unsigned         full_seen;

        function new();
            capacity      = CAP_RESET;
            open_bins     = 0;
            errors        = 0;
            inputs_seen   = 0;
            results_seen  = 0;
            opened_seen   = 0;
            oversize_seen = 0;
            full_seen     = 0;
        endfunction

        function int unsigned pending();
            return expected_placements.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("ERROR at %0t: %s", $realtime, msg);
            end
        endtask

        function void predict_placements(t_in_item item);
            int unsigned         count;
            int unsigned         k;
            logic [WEIGHT_W:0]   total;
            t_out_item           res;
            bit                  fitted;
            inputs_seen++;
            if (item.start_req) begin
                open_bins = 0;
            end
            count = (item.copies > MAX_COPIES) ? MAX_COPIES : item.copies;
            for (int unsigned c = 0; c < count; c++) begin
                res             = '0;
                res.placed_type = item.item_type;
                fitted          = 1'b0;
                for (k = 0; k < open_bins && !fitted; k++) begin
                    total = {1'b0, bin_load[k]} + item.weight;
                    if (total <= {1'b0, capacity}) begin
                        bin_load[k]   = total[WEIGHT_W-1:0];
                        res.bin_index = k[BIN_IDX_W-1:0];
                        fitted        = 1'b1;
                    end
                end
                if (!fitted) begin
                    if (open_bins < NUM_BINS) begin
                        res.bin_index       = open_bins[BIN_IDX_W-1:0];
                        bin_load[open_bins] = item.weight;
                        open_bins++;
                        res.opened_new      = 1'b1;
                        res.oversize        = item.weight > capacity;
                    end else begin
                        res.table_full = 1'b1;
                    end
                end
                res.bins_used = open_bins[USED_W-1:0];
                res.last      = (c + 1 == count);
                expected_placements = {expected_placements, res};
            end
        endfunction

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want) begin
                report($sformatf("result %0d: %s is %0d, expected %0d",
                                 results_seen, name, got, want));
            end
        endtask

        task check_placement(t_out_item got);
            t_out_item want;
            results_seen++;
            if (expected_placements.size() == 0) begin
                report($sformatf("result %0d arrived with nothing expected", results_seen));
                return;
            end
            want = expected_placements.pop_front();
            opened_seen   += want.opened_new;
            oversize_seen += want.oversize;
            full_seen     += want.table_full;
            compare_field("bin_index",   got.bin_index,   want.bin_index);
            compare_field("placed_type", got.placed_type, want.placed_type);
            compare_field("opened_new",  got.opened_new,  want.opened_new);
            compare_field("oversize",    got.oversize,    want.oversize);
            compare_field("table_full",  got.table_full,  want.table_full);
            compare_field("bins_used",   got.bins_used,   want.bins_used);
            compare_field("last",        got.last,        want.last);
        endtask
    endclass

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_ready;
    t_in_item         i_in_item   = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_out_item        o_out_item;
    logic             i_cfg_we    = 1'b0;
    logic [CAP_W-1:0] i_cfg_data  = '0;

    placement_scoreboard sb = new();
    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned capacity_settings  = 0;
    int unsigned cycles             = 0;

    first_fit_bin_packer_top #(
        .MAX_BINS    (NUM_BINS),
        .WEIGHT_BITS (WEIGHT_W)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL first_fit_bin_packer_top");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_placement(o_out_item);
        end
    end

    task send_item(t_in_item item);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        sb.predict_placements(item);
        @(negedge i_clk);
    endtask

    task send_fields(bit start, int unsigned kind, int unsigned w, int unsigned n);
        t_in_item item;
        item.start_req = start;
        item.item_type = kind[TYPE_W-1:0];
        item.weight    = w[WEIGHT_W-1:0];
        item.copies    = n[COPIES_W-1:0];
        send_item(item);
    endtask

    task wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Let tokens of items without results leave the chain before the capacity changes.
    task settle_block();
        receiver_stall_pct = 0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task write_capacity(int unsigned value);
        i_cfg_we    <= 1'b1;
        i_cfg_data  <= value[CAP_W-1:0];
        sb.capacity  = value[CAP_W-1:0];
        capacity_settings++;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic t_in_item random_item(bit start, int unsigned cap);
        t_in_item    item;
        int unsigned pick;
        item.start_req = start;
        item.item_type = TYPE_W'($urandom_range(1023));
        pick = $urandom_range(99);
        if (pick < 70) begin
            item.weight = WEIGHT_W'($urandom_range(cap));
        end else if (pick < 80) begin
            item.weight = WEIGHT_W'($urandom());
        end else if (pick < 88) begin
            item.weight = '0;
        end else if (pick < 95) begin
            item.weight = cap[WEIGHT_W-1:0];
        end else begin
            item.weight = cap[WEIGHT_W-1:0] + 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 65) begin
            item.copies = COPIES_W'($urandom_range(8, 1));
        end else if (pick < 85) begin
            item.copies = COPIES_W'($urandom_range(64, 9));
        end else if (pick < 92) begin
            item.copies = '0;
        end else begin
            item.copies = COPIES_W'($urandom_range(127, 65));
        end
        return item;
    endfunction

    initial begin
        int unsigned phase_cap [NUM_PHASES];
        int unsigned idle_of_mode [4];
        int unsigned stall_of_mode [4];
        int unsigned seq_left;
        bit          start;

        idle_of_mode  = '{0, 62, 0, 18};
        stall_of_mode = '{0, 0, 62, 18};
        phase_cap     = '{65535, $urandom_range(300, 2), 1000, 1,
                          $urandom_range(65535, 1), 50, $urandom_range(20, 2), 65535};

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Capacity still at its reset value: fill every bin, then overflow the table.
        send_fields(1, 0, 0, 1);
        send_fields(0, 1023, 65535, 2);
        send_fields(0, 5, 1234, 0);
        send_fields(0, 682, 65535, 127);
        send_fields(0, 341, 65535, 65);
        send_fields(0, 7, 65535, 64);
        send_fields(0, 8, 65535, 64);
        send_fields(0, 9, 0, 3);
        send_fields(0, 10, 1, 2);
        send_fields(1, 11, 500, 0);
        send_fields(0, 12, 100, 3);

        settle_block();
        write_capacity(10);
        send_fields(1, 13, 11, 2);
        send_fields(0, 14, 0, 1);
        send_fields(0, 15, 10, 1);
        send_fields(0, 16, 5, 3);
        send_fields(0, 17, 32768, 1);

        settle_block();
        write_capacity(0);
        send_fields(1, 18, 0, 2);
        send_fields(0, 19, 1, 1);
        send_fields(0, 20, 0, 1);

        settle_block();
        write_capacity(1);
        send_fields(1, 21, 1, 2);
        send_fields(0, 22, 32768, 1);
        send_fields(0, 23, 0, 2);

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle_block();
            write_capacity(phase_cap[p]);
            sender_idle_pct    = idle_of_mode[p % 4];
            receiver_stall_pct = stall_of_mode[p % 4];
            seq_left = 0;
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                if (p == 1 && i == RANDOM_PER_PHASE / 2) begin
                    wait_drained();
                end
                if (seq_left == 0) begin
                    seq_left = $urandom_range(15, 3);
                    start    = 1'b1;
                end else begin
                    start = ($urandom_range(99) < 5);
                end
                seq_left--;
                send_item(random_item(start, phase_cap[p]));
            end
        end

        sender_idle_pct = 0;
        settle_block();

        $display("Run covered %0d input and %0d result transactions over %0d capacity settings.",
                 sb.inputs_seen, sb.results_seen, capacity_settings);
        $display("Bins opened: %0d, oversize bins: %0d, copies dropped on a full table: %0d.",
                 sb.opened_seen, sb.oversize_seen, sb.full_seen);
        if (sb.errors == 0) begin
            $display("PASS first_fit_bin_packer_top");
        end else begin
            $display("FAIL first_fit_bin_packer_top");
        end
        $finish;
    end

endmodule

[files.f]
rtl/ffbp_pkg.sv
rtl/ffbp_cell.sv
rtl/ffbp_feed.sv
rtl/first_fit_bin_packer_top.sv
sim/tb.sv
